// ===== hw/rtl/three_band_equalizer_assert.svh =====
// assertion macros for the three band equaliser checker
// both sample on clk and are disabled while arst_n is low
`ifndef THREE_BAND_EQUALIZER_ASSERT_SVH
`define THREE_BAND_EQUALIZER_ASSERT_SVH

// same-cycle implication
`define TBE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("three band equaliser check failed");

// next-cycle implication
`define TBE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("three band equaliser check failed");

`endif

// ===== hw/rtl/tbe_pkg.sv =====
// shared types and constants of the three band equaliser
// used by the top, lane, sequencer and merge modules, no dependencies
package tbe_pkg;

	// default sizes
	localparam int DEF_LANES       = 4;
	localparam int DEF_SAMPLE_BITS = 16;

	// arithmetic formats
	localparam int STAGES     = 4;
	localparam int STAGE_W    = 2;
	localparam int HIST_DEPTH = 3;
	localparam int COEF_W     = 17;
	localparam int GAIN_W     = 16;
	localparam int POLE_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int GAIN_FRAC  = 12;
	localparam int OUT_SHIFT  = FRAC_BITS + GAIN_FRAC;

	// sequencer schedule: pole updates, then the three mixing products
	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] CNT_MIX_LO     = CNT_W'(2 * STAGES);
	localparam logic [CNT_W-1:0] CNT_MIX_HI     = CNT_W'(2 * STAGES + 1);
	localparam logic [CNT_W-1:0] CNT_LAST_ISSUE = CNT_W'(2 * STAGES + 2);
	localparam logic [CNT_W-1:0] CNT_LAST       = CNT_W'(2 * STAGES + 3);

	// register map
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = COEF_W;
	localparam logic [REG_IDX_W-1:0] REG_LOW_COEF  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_COEF = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LOW_GAIN  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MID_GAIN  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_GAIN = 3'd4;

	// reset values, unity gain is 1.0 in Q4.12
	localparam logic [COEF_W-1:0] RST_LOW_COEF  = 17'd7547;
	localparam logic [COEF_W-1:0] RST_HIGH_COEF = 17'd42457;
	localparam logic [GAIN_W-1:0] RST_GAIN_UNITY = 16'd4096;

	typedef enum logic [2:0] {
		OP_LOW,
		OP_HIGH,
		OP_MIX_LO,
		OP_MIX_HI,
		OP_DRY
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [COEF_W-1:0] low_coef;
		logic [COEF_W-1:0] high_coef;
		logic [GAIN_W-1:0] low_gain;
		logic [GAIN_W-1:0] mid_gain;
		logic [GAIN_W-1:0] high_gain;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic               issue;
		op_t                op;
		logic [STAGE_W-1:0] stage;
		logic               load;
	} ctrl_t;

endpackage

// ===== hw/rtl/three_band_equalizer.sv =====
// Three band equaliser over LANES audio channels carried side by side in one
// transfer. Each lane runs a low and a high cascade of four one-pole lowpass
// stages, splits low, mid and high bands, weights them by Q4.12 gains and
// saturates the sum, flagging clipped lanes in m_tuser. One item is in work
// at a time: after an accepted input transfer the single multiplier of each
// lane does the eight pole updates and three mixing products in turn, the
// result is loaded into the output register once that register is free, and
// only then is the next input taken. Registers are to be written through
// cfg_we/cfg_index/cfg_wdata only while no item is in work; the block itself
// does not enforce this. All filter state and sample history are cleared by
// arst_n.
module three_band_equalizer import tbe_pkg::*; #(
	parameter int LANES       = DEF_LANES,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// sample_lane0 .. sample_lane(LANES-1), then zero padding
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	// eq_lane0 .. eq_lane(LANES-1), then zero padding
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	// clip_mask
	output logic [LANES-1:0]                       m_tuser,
	input  logic                                   cfg_we,
	input  logic [REG_IDX_W-1:0]                   cfg_index,
	input  logic [CFG_W-1:0]                       cfg_wdata
);

	cfg_t                         cfg_q;
	ctrl_t                        ctrl;
	logic                         out_free;
	logic [LANES*SAMPLE_BITS-1:0] eq_lanes;
	logic [LANES-1:0]             clip_lanes;

	// configuration registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_coef  <= RST_LOW_COEF;
			cfg_q.high_coef <= RST_HIGH_COEF;
			cfg_q.low_gain  <= RST_GAIN_UNITY;
			cfg_q.mid_gain  <= RST_GAIN_UNITY;
			cfg_q.high_gain <= RST_GAIN_UNITY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOW_COEF:  cfg_q.low_coef  <= cfg_wdata;
				REG_HIGH_COEF: cfg_q.high_coef <= cfg_wdata;
				REG_LOW_GAIN:  cfg_q.low_gain  <= cfg_wdata[GAIN_W-1:0];
				REG_MID_GAIN:  cfg_q.mid_gain  <= cfg_wdata[GAIN_W-1:0];
				REG_HIGH_GAIN: cfg_q.high_gain <= cfg_wdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	tbe_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.out_free (out_free),
		.s_tready (s_tready),
		.ctrl     (ctrl)
	);

	// lanes
	for (genvar n = 0; n < LANES; n++) begin : g_lane
		tbe_lane #(
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.cfg    (cfg_q),
			.sample (s_tdata[n*SAMPLE_BITS +: SAMPLE_BITS]),
			.eq     (eq_lanes[n*SAMPLE_BITS +: SAMPLE_BITS]),
			.clip   (clip_lanes[n])
		);
	end

	// result merge and output register
	tbe_merge #(
		.LANES       (LANES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.eq_lanes   (eq_lanes),
		.clip_lanes (clip_lanes),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.out_free   (out_free)
	);

endmodule

// ===== hw/rtl/tbe_lane.sv =====
// one equaliser lane: pole cascades, history and band mixing
// one shared multiplier, steered by the sequencer; depends on tbe_pkg
module tbe_lane import tbe_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ctrl_t                         ctrl,
	input  cfg_t                          cfg,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SAMPLE_BITS-1:0] eq,
	output logic                          clip
);

	localparam int XW    = (SAMPLE_BITS + FRAC_BITS > POLE_W) ? SAMPLE_BITS + FRAC_BITS : POLE_W;
	localparam int AW    = XW + 1;
	localparam int BW    = GAIN_W + 2;
	localparam int PW    = AW + BW;
	localparam int SW    = PW - FRAC_BITS;
	localparam int DRY_W = SAMPLE_BITS + BW + FRAC_BITS;
	localparam int ACC_W = ((DRY_W > POLE_W + BW) ? DRY_W : POLE_W + BW) + 2;
	localparam int YW    = ACC_W - OUT_SHIFT;

	// state
	logic signed [POLE_W-1:0]      low_q  [STAGES];
	logic signed [POLE_W-1:0]      high_q [STAGES];
	logic signed [SAMPLE_BITS-1:0] hist_q [HIST_DEPTH];
	logic signed [XW-1:0]          x_low_q;
	logic signed [XW-1:0]          x_high_q;
	logic signed [SAMPLE_BITS-1:0] dry_q;
	logic signed [ACC_W-1:0]       acc_q;

	// multiplier stage
	logic                          wb_s1;
	logic signed [PW-1:0]          prod_s1;
	op_t                           op_s1;
	logic [STAGE_W-1:0]            stage_s1;
	logic signed [POLE_W-1:0]      pole_s1;

	logic signed [POLE_W-1:0]      pole_rd;
	logic signed [AW-1:0]          a_op;
	logic signed [BW-1:0]          b_op;
	logic signed [PW-1:0]          prod;
	logic signed [SW-1:0]          step;
	logic signed [SW:0]            sum;
	logic                          sum_fits;
	logic signed [POLE_W-1:0]      pole_new;
	logic signed [ACC_W-1:0]       acc_add;
	logic signed [YW-1:0]          y;
	logic                          y_fits;

	// operand selection for the issued operation
	always_comb begin
		pole_rd = low_q[ctrl.stage];
		a_op    = '0;
		b_op    = '0;
		unique case (ctrl.op)
			OP_LOW: begin
				pole_rd = low_q[ctrl.stage];
				a_op    = AW'(x_low_q) - AW'(pole_rd);
				b_op    = BW'(cfg.low_coef);
			end
			OP_HIGH: begin
				pole_rd = high_q[ctrl.stage];
				a_op    = AW'(x_high_q) - AW'(pole_rd);
				b_op    = BW'(cfg.high_coef);
			end
			OP_MIX_LO: begin
				a_op = AW'(x_low_q);
				b_op = BW'(cfg.low_gain) - BW'(cfg.mid_gain);
			end
			OP_MIX_HI: begin
				a_op = AW'(x_high_q);
				b_op = BW'(cfg.mid_gain) - BW'(cfg.high_gain);
			end
			OP_DRY: begin
				a_op = AW'(dry_q);
				b_op = BW'(cfg.high_gain);
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign prod = a_op * b_op;

	// pole update with saturation to the pole register range
	assign step     = SW'(prod_s1 >>> FRAC_BITS);
	assign sum      = (SW + 1)'(pole_s1) + (SW + 1)'(step);
	assign sum_fits = (&sum[SW:POLE_W-1]) | ~(|sum[SW:POLE_W-1]);
	assign pole_new = sum_fits ? sum[POLE_W-1:0] :
		(sum[SW] ? {1'b1, {(POLE_W-1){1'b0}}} : {1'b0, {(POLE_W-1){1'b1}}});

	// dry product carries the 2^16 of the delayed sample
	assign acc_add = (op_s1 == OP_DRY) ? (ACC_W'(prod_s1) <<< FRAC_BITS) : ACC_W'(prod_s1);

	// output scaling and clipping
	assign y      = YW'(acc_q >>> OUT_SHIFT);
	assign y_fits = (&y[YW-1:SAMPLE_BITS-1]) | ~(|y[YW-1:SAMPLE_BITS-1]);
	assign eq     = y_fits ? y[SAMPLE_BITS-1:0] :
		(y[YW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}});
	assign clip   = ~y_fits;

	// multiplier output register
	always_ff @(posedge clk) begin
		prod_s1  <= prod;
		op_s1    <= ctrl.op;
		stage_s1 <= ctrl.stage;
		pole_s1  <= pole_rd;
	end

	// filter state and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_s1  <= 1'b0;
			low_q  <= '{default: '0};
			high_q <= '{default: '0};
			hist_q <= '{default: '0};
		end else begin
			wb_s1 <= ctrl.issue;
			if (ctrl.start) begin
				hist_q[0] <= sample;
				hist_q[1] <= hist_q[0];
				hist_q[2] <= hist_q[1];
			end
			if (wb_s1) begin
				unique case (op_s1)
					OP_LOW:  low_q[stage_s1]  <= pole_new;
					OP_HIGH: high_q[stage_s1] <= pole_new;
					default: ;
				endcase
			end
		end
	end

	// cascade inputs, delayed sample and mix accumulator
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			x_low_q  <= XW'(sample) <<< FRAC_BITS;
			x_high_q <= XW'(sample) <<< FRAC_BITS;
			dry_q    <= hist_q[2];
			acc_q    <= '0;
		end else if (wb_s1) begin
			unique case (op_s1)
				OP_LOW:                      x_low_q  <= XW'(pole_new);
				OP_HIGH:                     x_high_q <= XW'(pole_new);
				OP_MIX_LO, OP_MIX_HI, OP_DRY: acc_q   <= acc_q + acc_add;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/tbe_seq.sv =====
// sequencer of the three band equaliser
// steps all lanes in lockstep through one item; depends on tbe_pkg
module tbe_seq import tbe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	input  logic  out_free,
	output logic  s_tready,
	output ctrl_t ctrl
);

	state_t             state_q;
	state_t             state_d;
	logic [CNT_W-1:0]   cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid)          state_d = ST_RUN;
			ST_RUN:  if (cnt_q == CNT_LAST) state_d = ST_FIN;
			ST_FIN:  if (out_free)          state_d = ST_IDLE;
			default:                        state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready   = 1'b0;
		ctrl.start = 1'b0;
		ctrl.issue = 1'b0;
		ctrl.load  = 1'b0;
		ctrl.stage = cnt_q[STAGE_W:1];
		// operation of the current step: low/high pole pairs, then mixing
		if (cnt_q < CNT_MIX_LO) begin
			ctrl.op = cnt_q[0] ? OP_HIGH : OP_LOW;
		end else if (cnt_q == CNT_MIX_LO) begin
			ctrl.op = OP_MIX_LO;
		end else if (cnt_q == CNT_MIX_HI) begin
			ctrl.op = OP_MIX_HI;
		end else begin
			ctrl.op = OP_DRY;
		end
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				ctrl.start = s_tvalid;
			end
			ST_RUN:  ctrl.issue = (cnt_q <= CNT_LAST_ISSUE);
			ST_FIN:  ctrl.load  = out_free;
			default: ;
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

// ===== hw/rtl/tbe_merge.sv =====
// merge stage: gathers lane results and clip flags into the output register
// depends on tbe_pkg
module tbe_merge import tbe_pkg::*; #(
	parameter int LANES       = DEF_LANES,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ctrl_t                                  ctrl,
	input  logic [LANES*SAMPLE_BITS-1:0]           eq_lanes,
	input  logic [LANES-1:0]                       clip_lanes,
	input  logic                                   m_tready,
	output logic                                   m_tvalid,
	output logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	output logic [LANES-1:0]                       m_tuser,
	output logic                                   out_free
);

	localparam int DW = ((LANES * SAMPLE_BITS + 7) / 8) * 8;

	logic          valid_q;
	logic [DW-1:0] data_q;
	logic [LANES-1:0] user_q;

	assign out_free = ~valid_q | m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= DW'(eq_lanes);
			user_q <= clip_lanes;
		end
	end

endmodule

// ===== hw/rtl/tbe_checker.sv =====
// port-level checks of the three band equaliser, bound to the top level
// uses the macros of three_band_equalizer_assert.svh
`include "three_band_equalizer_assert.svh"

module tbe_checker #(
	parameter int LANES       = 4,
	parameter int SAMPLE_BITS = 16
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_tvalid,
	input logic                                   s_tready,
	input logic                                   m_tvalid,
	input logic                                   m_tready,
	input logic [((LANES*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	input logic [LANES-1:0]                       m_tuser
);

	localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// a stalled result holds
	`TBE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// the block is busy in the cycle after taking a transfer
	`TBE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

	// a result only appears at the end of work on an item
	`TBE_ASSERT_IMP(a_result_after_work, $rose(m_tvalid), $past(!s_tready))

	// a clipped lane sits on a rail
	for (genvar n = 0; n < LANES; n++) begin : g_clip
		`TBE_ASSERT_IMP(a_clip_at_rail, m_tvalid && m_tuser[n], m_tdata[n*SAMPLE_BITS +: SAMPLE_BITS] == S_MAX || m_tdata[n*SAMPLE_BITS +: SAMPLE_BITS] == S_MIN)
	end

endmodule

bind three_band_equalizer tbe_checker #(
	.LANES       (LANES),
	.SAMPLE_BITS (SAMPLE_BITS)
) u_tbe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
